[sv/mssp_pkg.sv]
// Shared constants, register indexes and helper functions of the servo pulse sequencer.
package mssp_pkg;

  localparam int NUM_SERVOS  = 5;
  localparam int CHAN_W      = $clog2(NUM_SERVOS + 1);
  localparam int ANGLE_W     = 8;
  localparam int ORIGIN_W    = 16;
  localparam int STEP_W      = 8;
  localparam int PERIOD_W    = 16;
  localparam int LEN_W       = ORIGIN_W + 1;
  localparam int ELAPSED_W   = 20;
  localparam int APB_DATA_W  = 64;
  localparam int APB_ADDR_W  = 6;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 16;

  localparam logic [CHAN_W-1:0]    IDLE_CODE   = CHAN_W'(NUM_SERVOS);
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  localparam logic [ORIGIN_W-1:0] ORIGIN_RESET = 16'd1000;
  localparam logic [STEP_W-1:0]   STEP_RESET   = 8'd5;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd20000;

  typedef enum logic [2:0] {
    RegAngles = 3'd0,
    RegEnable = 3'd1,
    RegOrigin = 3'd2,
    RegStep   = 3'd3,
    RegPeriod = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic                  frame_start;
    logic [CHAN_W-1:0]     active_channel;
    logic [NUM_SERVOS-1:0] pin_levels;
  } result_t;

  // Returns the lowest set bit position, or NUM_SERVOS when no bit is set.
  function automatic logic [CHAN_W-1:0] first_chan(input logic [NUM_SERVOS-1:0] m);
    logic [CHAN_W-1:0] idx;
    idx = IDLE_CODE;
    for (int i = NUM_SERVOS - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = CHAN_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

[sv/multiplexed_servo_pulse_sequencer.sv]
// Top level of the multiplexed servo pulse sequencer with its register port and result buffer.
//
//  channel   | direction | handshake               | payload
//  s_axis    | in        | s_axis_tvalid/tready    | tick_valid
//  m_axis    | out       | m_axis_tvalid/tready    | pin_levels, active_channel, frame_start
//  apb       | in        | psel/penable, pready=1  | five configuration registers
//
// Each tick transaction yields one result, registered in the output slot or, while it stalls,
// in the second slot; the next-segment logic (channel search, one 8x8 multiply, one saturating
// add) sits between the sequencer state registers and the result register.
// Synchronous reset clears the sequencer state and both result slots.
// A stalled output fills a second result slot; ready drops only while both are full.
module multiplexed_servo_pulse_sequencer
  import mssp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [0] tick_valid, [7:1] zero
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [4:0] pin_levels, [7:5] active_channel,
                                                // [8] frame_start, [15:9] zero
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [NUM_SERVOS-1:0][ANGLE_W-1:0] servo_angles;
  logic [NUM_SERVOS-1:0]              enable_mask;
  logic [ORIGIN_W-1:0]                pulse_origin;
  logic [STEP_W-1:0]                  pulse_step;
  logic [PERIOD_W-1:0]                frame_period;

  logic [CHAN_W-1:0]    current_channel, current_channel_next;
  logic [LEN_W-1:0]     countdown, countdown_next;
  logic [ELAPSED_W-1:0] frame_elapsed, frame_elapsed_next;
  logic                 in_gap, in_gap_next;

  logic    out_valid, skid_valid;
  result_t out_data, skid_data, result;

  logic [2:0] reg_sel;
  logic       cfg_write;
  logic       in_accept;
  logic       tick;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[APB_ADDR_W-1:3];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      servo_angles <= '0;
      enable_mask  <= '0;
      pulse_origin <= ORIGIN_RESET;
      pulse_step   <= STEP_RESET;
      frame_period <= PERIOD_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        RegAngles: servo_angles <= pwdata[NUM_SERVOS*ANGLE_W-1:0];
        RegEnable: enable_mask  <= pwdata[NUM_SERVOS-1:0];
        RegOrigin: pulse_origin <= pwdata[ORIGIN_W-1:0];
        RegStep:   pulse_step   <= pwdata[STEP_W-1:0];
        RegPeriod: frame_period <= pwdata[PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegAngles: prdata = APB_DATA_W'(servo_angles);
      RegEnable: prdata = APB_DATA_W'(enable_mask);
      RegOrigin: prdata = APB_DATA_W'(pulse_origin);
      RegStep:   prdata = APB_DATA_W'(pulse_step);
      RegPeriod: prdata = APB_DATA_W'(frame_period);
      default:   prdata = '0;
    endcase
  end

  logic [NUM_SERVOS-1:0]       below_mask, from_mask;
  logic [CHAN_W-1:0]           ch_from, ch_any, pulse_ch, angle_idx;
  logic                        found_from, found_any, gap_ok, fresh;
  logic                        do_pulse, restart;
  logic [STEP_W+ANGLE_W-1:0]   pulse_prod;
  logic [LEN_W-1:0]            pulse_len, gap_len;
  logic [ELAPSED_W:0]          pulse_sum;
  logic                        frame_start;

  assign tick       = s_axis_tdata[0];
  assign below_mask = (NUM_SERVOS'(1) << current_channel) - NUM_SERVOS'(1);
  assign from_mask  = enable_mask & ~below_mask;
  assign ch_from    = first_chan(from_mask);
  assign ch_any     = first_chan(enable_mask);
  assign found_from = ch_from != IDLE_CODE;
  assign found_any  = ch_any != IDLE_CODE;
  assign gap_ok     = frame_elapsed < ELAPSED_W'(frame_period);
  assign fresh      = current_channel == '0;

  always_comb begin
    do_pulse    = 1'b0;
    restart     = 1'b0;
    pulse_ch    = ch_from;
    gap_len     = LEN_W'(1);
    frame_start = fresh;
    priority if (found_from) begin
      do_pulse = 1'b1;
    end else if (gap_ok) begin
      gap_len = LEN_W'(frame_period - frame_elapsed[PERIOD_W-1:0]);
    end else begin
      restart     = 1'b1;
      frame_start = 1'b1;
      do_pulse    = found_any;
      pulse_ch    = ch_any;
    end
  end

  assign angle_idx  = do_pulse ? pulse_ch : '0;
  assign pulse_prod = pulse_step * servo_angles[angle_idx];
  assign pulse_len  = LEN_W'(pulse_origin) + LEN_W'(pulse_prod);
  assign pulse_sum  = (restart ? (ELAPSED_W + 1)'(0) : (ELAPSED_W + 1)'(frame_elapsed))
                    + (ELAPSED_W + 1)'(pulse_len);

  always_comb begin
    current_channel_next = current_channel;
    countdown_next       = countdown;
    frame_elapsed_next   = frame_elapsed;
    in_gap_next          = in_gap;
    result.frame_start   = 1'b0;
    if (tick) begin
      if (countdown != '0) begin
        countdown_next = countdown - LEN_W'(1);
      end else begin
        result.frame_start = frame_start;
        if (do_pulse) begin
          frame_elapsed_next   = pulse_sum[ELAPSED_W] ? ELAPSED_MAX : pulse_sum[ELAPSED_W-1:0];
          countdown_next       = (pulse_len == '0) ? '0 : pulse_len - LEN_W'(1);
          current_channel_next = pulse_ch + CHAN_W'(1);
          in_gap_next          = 1'b0;
        end else begin
          frame_elapsed_next   = '0;
          countdown_next       = gap_len - LEN_W'(1);
          current_channel_next = '0;
          in_gap_next          = 1'b1;
        end
      end
    end
    if (!in_gap_next && current_channel_next != '0) begin
      result.active_channel = current_channel_next - CHAN_W'(1);
      result.pin_levels     = NUM_SERVOS'(1) << result.active_channel;
    end else begin
      result.active_channel = IDLE_CODE;
      result.pin_levels     = '0;
    end
  end

  assign s_axis_tready = !skid_valid;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_channel <= '0;
      countdown       <= '0;
      frame_elapsed   <= '0;
      in_gap          <= 1'b0;
    end else if (in_accept) begin
      current_channel <= current_channel_next;
      countdown       <= countdown_next;
      frame_elapsed   <= frame_elapsed_next;
      in_gap          <= in_gap_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_axis_tready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_axis_tready || !out_valid) begin
      out_data <= skid_valid ? skid_data : result;
    end else if (in_accept) begin
      skid_data <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_DATA_W'(out_data);

endmodule

[sv/mssp_checker.sv]
// Port-level checker of the servo pulse sequencer and its bind statement.
module mssp_checker
  import mssp_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic [NUM_SERVOS-1:0] pins;
  logic [CHAN_W-1:0]     active;

  assign pins   = m_axis_tdata[NUM_SERVOS-1:0];
  assign active = m_axis_tdata[NUM_SERVOS+CHAN_W-1:NUM_SERVOS];

  a_one_pin: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $onehot0(pins))
    else $error("More than one servo output is high.");

  a_pin_matches_channel: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((active == IDLE_CODE) ? (pins == '0)
                                             : (pins == (NUM_SERVOS'(1) << active))))
    else $error("Output levels disagree with the active channel.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("A stalled result transaction changed.");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("Input is stalled while no result is waiting.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("A result is offered right after reset.");

endmodule

bind multiplexed_servo_pulse_sequencer mssp_checker u_mssp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[bench/tb_multiplexed_servo_pulse_sequencer.sv]
// Self-checking testbench for the multiplexed servo pulse sequencer with a stream and APB driver.
`timescale 1ns / 1ps

module tb_multiplexed_servo_pulse_sequencer;
  import mssp_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 20;

  typedef enum int {
    RxOpen,
    RxCoin,
    RxMostly,
    RxThird
  } rx_mode_t;

  class servo_frame_board;
    logic [39:0]           angles;
    logic [NUM_SERVOS-1:0] en_mask;
    logic [ORIGIN_W-1:0]   origin;
    logic [STEP_W-1:0]     step;
    logic [PERIOD_W-1:0]   period;

    logic [CHAN_W-1:0]     next_ch;
    logic [ELAPSED_W-1:0]  left;
    logic [ELAPSED_W-1:0]  elapsed;
    bit                    gap;

    result_t               due_levels[$];
    int                    mismatches;
    int                    checked;
    int                    frames;

    function new();
      angles     = '0;
      en_mask    = '0;
      origin     = ORIGIN_RESET;
      step       = STEP_RESET;
      period     = PERIOD_RESET;
      next_ch    = '0;
      left       = '0;
      elapsed    = '0;
      gap        = 1'b0;
      mismatches = 0;
      checked    = 0;
      frames     = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] val);
      case (idx)
        RegAngles: angles = val[39:0];
        RegEnable: en_mask = val[NUM_SERVOS-1:0];
        RegOrigin: origin = val[ORIGIN_W-1:0];
        RegStep:   step = val[STEP_W-1:0];
        RegPeriod: period = val[PERIOD_W-1:0];
        default: ;
      endcase
    endfunction

    function int first_on(int from);
      for (int c = from; c < NUM_SERVOS; c++) begin
        if (en_mask[c]) return c;
      end
      return -1;
    endfunction

    function void open_pulse(int ch);
      int unsigned len;
      int unsigned sum;
      len = origin + step * angles[ch*8 +: 8];
      sum = elapsed + len;
      elapsed = (sum > ELAPSED_MAX) ? ELAPSED_MAX : sum[ELAPSED_W-1:0];
      left = (len == 0) ? '0 : ELAPSED_W'(len - 1);
      next_ch = CHAN_W'(ch + 1);
      gap = 1'b0;
    endfunction

    function void open_gap(int unsigned len);
      left = (len == 0) ? '0 : ELAPSED_W'(len - 1);
      next_ch = '0;
      gap = 1'b1;
    endfunction

    function bit advance();
      bit fresh;
      int ch;
      fresh = (next_ch == 0);
      ch = first_on(next_ch);
      if (ch >= 0) begin
        open_pulse(ch);
        return fresh;
      end
      if (elapsed < period) begin
        open_gap(period - elapsed);
        elapsed = '0;
        return fresh;
      end
      elapsed = '0;
      ch = first_on(0);
      if (ch >= 0) open_pulse(ch);
      else open_gap(1);
      return 1'b1;
    endfunction

    function int pulsing();
      if (!gap && next_ch != 0) return next_ch - 1;
      return IDLE_CODE;
    endfunction

    function void take_tick(bit tick);
      result_t r;
      int act;
      r = '0;
      if (tick) begin
        if (left == 0) r.frame_start = advance();
        else left--;
      end
      act = pulsing();
      r.active_channel = CHAN_W'(act);
      if (act < NUM_SERVOS) r.pin_levels = NUM_SERVOS'(1) << act;
      due_levels.push_back(r);
    endfunction

    function void match_output(logic [OUT_DATA_W-1:0] word);
      result_t want;
      result_t got;
      got = word[$bits(result_t)-1:0];
      if (due_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", word);
        return;
      end
      want = due_levels.pop_front();
      checked++;
      if (want.frame_start) frames++;
      if (got.pin_levels !== want.pin_levels || got.active_channel !== want.active_channel ||
          got.frame_start !== want.frame_start ||
          word[OUT_DATA_W-1:$bits(result_t)] !== '0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d: want pins %b ch %0d fs %b, got pins %b ch %0d fs %b pad %h",
                   checked, want.pin_levels, want.active_channel, want.frame_start,
                   got.pin_levels, got.active_channel, got.frame_start,
                   word[OUT_DATA_W-1:$bits(result_t)]);
        end
      end
    endfunction

    function int pending();
      return due_levels.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  servo_frame_board board = new();

  int       cycles = 0;
  int       ticks_sent = 0;
  int       reg_writes = 0;
  int       burst_left = 0;
  bit       steady = 1'b0;
  int       hold_ask = 0;

  multiplexed_servo_pulse_sequencer dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_multiplexed_servo_pulse_sequencer: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) board.take_tick(s_axis_tdata[0]);
      if (m_axis_tvalid && m_axis_tready) board.match_output(m_axis_tdata);
    end
  end

  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    int       rx_tick;
    mode = RxOpen;
    mode_left = 0;
    hold_left = 0;
    rx_tick = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      rx_tick++;
      if (hold_ask > 0) begin
        hold_left = hold_ask;
        hold_ask = 0;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (steady) begin
        m_axis_tready <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 80);
        end
        mode_left--;
        case (mode)
          RxOpen:   m_axis_tready <= 1'b1;
          RxCoin:   m_axis_tready <= 1'($urandom_range(0, 1));
          RxMostly: m_axis_tready <= ($urandom_range(0, 9) != 0);
          RxThird:  m_axis_tready <= (rx_tick % 3 == 0);
          default:  m_axis_tready <= 1'b1;
        endcase
      end
    end
  end

  task automatic push_tick(input bit tv);
    int gap;
    if (!steady) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        burst_left = $urandom_range(1, 24);
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      burst_left--;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W-1){1'b0}}, tv};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(8 * int'(idx));
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.set_reg(idx, val);
    reg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    bit                  started;
    logic [STEP_W-1:0]   st;
    logic [39:0]         ang;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Idle outputs after reset, held ticks, and a zero period with nothing enabled.
    apb_write(RegPeriod, 64'd0);
    push_tick(1'b0);
    push_tick(1'b1);
    push_tick(1'b1);
    push_tick(1'b0);
    push_tick(1'b1);
    drain();

    // Zero-length pulses on every channel followed by a short gap.
    apb_write(RegOrigin, 64'd0);
    apb_write(RegStep, 64'd0);
    apb_write(RegEnable, 64'h1F);
    apb_write(RegPeriod, 64'd3);
    repeat (9) push_tick(1'b1);
    drain();

    // Pulses that fill the period, so the next frame starts at once.
    apb_write(RegOrigin, 64'd1);
    apb_write(RegStep, 64'd2);
    apb_write(RegAngles, 64'h00_0000_0100);
    apb_write(RegEnable, 64'h0A);
    apb_write(RegPeriod, 64'd4);
    push_tick(1'b1);
    push_tick(1'b1);
    push_tick(1'b1);
    push_tick(1'b0);
    repeat (6) push_tick(1'b1);
    drain();

    // A pulse on the top channel whose step product needs more than eight bits.
    apb_write(RegAngles, 64'h10_0000_0000);
    apb_write(RegOrigin, 64'd0);
    apb_write(RegStep, 64'h10);
    apb_write(RegPeriod, 64'hFFFF);
    apb_write(RegEnable, 64'h10);
    steady = 1'b1;
    started = 1'b0;
    forever begin
      push_tick(($urandom_range(0, 999) != 0));
      if (board.left > 200) started = 1'b1;
      if (started && board.pulsing() == NUM_SERVOS - 1 && board.left <= 1) break;
    end
    drain();
    steady = 1'b0;
    apb_write(RegEnable, 64'h00);
    apb_write(RegPeriod, 64'd0);
    repeat (4) push_tick(1'b1);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      st = STEP_W'($urandom_range(0, 3));
      if (st == 0) ang = {8'($urandom()), 32'($urandom())};
      else begin
        for (int c = 0; c < NUM_SERVOS; c++) ang[c*8 +: 8] = 8'($urandom_range(0, 4));
      end
      apb_write(RegAngles, 64'(ang));
      apb_write(RegStep, 64'(st));
      apb_write(RegOrigin, 64'($urandom_range(0, 6)));
      apb_write(RegEnable, (ph == 1) ? 64'h1F : 64'($urandom_range(0, 31)));
      apb_write(RegPeriod, 64'($urandom_range(0, 40)));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 2 && i == 8) hold_ask = 60;
        if (ph == 5 && i == 10) drain();
        push_tick(($urandom_range(0, 99) < 85));
      end
      drain();
    end

    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("run covered %0d tick transactions and %0d register writes over %0d settings",
             ticks_sent, reg_writes, RAND_PHASES + 5);
    $display("checked %0d results, %0d frame starts, %0d mismatches, %0d left waiting",
             board.checked, board.frames, board.mismatches, board.pending());
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("tb_multiplexed_servo_pulse_sequencer: done, clean");
    end else begin
      $display("tb_multiplexed_servo_pulse_sequencer: done, errors");
    end
    $finish;
  end

endmodule
